[src/rasr_pkg.sv]
// Package for the rational add/subtract/reduce unit.
// Holds word types, status codes and shared widths; no dependencies.
`default_nettype none
package rasr_pkg;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned WW = 64;
  localparam int unsigned CW = 7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic        operands_equal;
    logic [1:0]  status;
  } out_word_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    logic        err;
    logic        eq;
    logic        neg_a;
    logic        neg_b;
    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [30:0] a_den;
    logic [30:0] b_den;
  } job_t;
endpackage
`default_nettype wire

[src/rational_add_sub_reduce_unit.sv]
// Top level of the rational add/subtract/reduce unit.
// Depends on rasr_pkg, rasr_front and rasr_back.
//
// Each word gives a op b (add or subtract), reduced to lowest terms, plus an
// equality flag and a status (ok, zero denominator, overflow). Words are taken
// into a two-entry queue; the back end works on one word at a time: it picks up
// the job, multiplies, sums, runs a binary GCD loop, divides numerator and
// denominator by the GCD in two 64-bit bit-serial passes of a shared divider,
// checks the range and hands over the result. A word with a zero denominator
// skips from the multiply step straight to the hand-over.
`default_nettype none
module rational_add_sub_reduce_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rasr_pkg::in_word_t in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rasr_pkg::out_word_t     out_word_o
);
  import rasr_pkg::*;

  logic job_valid, job_pop;
  job_t job;

  rasr_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_word_i(in_word_i), .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  rasr_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .job_valid_i(job_valid), .job_pop_o(job_pop),
    .job_i(job), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_word_o(out_word_o)
  );
endmodule
`default_nettype wire

[src/rasr_front.sv]
// Front end: accepts input words, classifies them and pushes jobs into a queue.
// Depends on rasr_pkg.
`default_nettype none
module rasr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rasr_pkg::in_word_t in_word_i,
  output logic                   job_valid_o,
  input  wire logic              job_pop_i,
  output rasr_pkg::job_t         job_o
);
  import rasr_pkg::*;

  job_t        fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  job_t        j;
  logic        push;
  logic        negb;

  always_comb begin
    negb = in_word_i.b_num[31] ^ in_word_i.mode;
    j.err = (in_word_i.a_den == '0) || (in_word_i.b_den == '0);
    j.eq = (in_word_i.a_num == in_word_i.b_num) && (in_word_i.a_den == in_word_i.b_den);
    j.neg_a = in_word_i.a_num[31];
    j.neg_b = negb;
    j.a_mag = in_word_i.a_num[31] ? (~in_word_i.a_num + 32'd1) : in_word_i.a_num;
    j.b_mag = in_word_i.b_num[31] ? (~in_word_i.b_num + 32'd1) : in_word_i.b_num;
    j.a_den = in_word_i.a_den;
    j.b_den = in_word_i.b_den;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= j;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (job_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_pop_i};
    end
  end
endmodule
`default_nettype wire

[src/rasr_back.sv]
// Back end: multiplies, adds or subtracts, reduces by a binary GCD, divides out the GCD and checks the range.
// Depends on rasr_pkg.
`default_nettype none
module rasr_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  output logic                    job_pop_o,
  input  wire rasr_pkg::job_t     job_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rasr_pkg::out_word_t     out_word_o
);
  import rasr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [WW-1:0] LIM = WW'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);

  logic [2:0]    st_q, st_d;
  job_t          job_q;
  logic [WW-1:0] p_q, q_q, den_q, mag_q, u_q, v_q, g_q;
  logic [WW-1:0] rem_q, quo_q, qd_q, rd_q, dvd_q;
  logic [CW-1:0] sh_q, cnt_q;
  logic          neg_q, pass_q;
  out_word_t     ow_q;
  logic          ov_q;
  logic [WW:0]   trial;
  logic [WW-1:0] dvsr;

  assign job_pop_o = (st_q == S_IDLE) && job_valid_i;
  assign out_valid_o = ov_q;
  assign out_word_o = ow_q;
  assign dvsr = g_q;
  assign trial = {rem_q[WW-1:0], dvd_q[WW-1]} - {1'b0, dvsr};

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (job_valid_i) st_d = S_MUL;
      S_MUL: st_d = job_q.err ? S_OUT : S_SUM;
      S_SUM: st_d = S_GCD;
      S_GCD: if (mag_q == '0 || v_q == '0) st_d = S_DIV;
      S_DIV: if (cnt_q == CW'(WW - 1) && pass_q) st_d = S_CHK;
      S_CHK: st_d = S_OUT;
      S_OUT: if (ov_q && !out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        job_q <= job_i;
      end
      S_MUL: begin
        p_q <= WW'(job_q.a_mag) * WW'(job_q.b_den);
        q_q <= WW'(job_q.b_mag) * WW'(job_q.a_den);
        den_q <= WW'(job_q.a_den) * WW'(job_q.b_den);
        ow_q.res_num <= '0;
        ow_q.res_den <= 31'd1;
        ow_q.operands_equal <= job_q.eq;
        ow_q.status <= job_q.err ? ST_ZERO_DEN : ST_OK;
      end
      S_SUM: begin
        if (job_q.neg_a == job_q.neg_b) begin
          mag_q <= p_q + q_q;
          neg_q <= job_q.neg_a;
        end else if (p_q >= q_q) begin
          mag_q <= p_q - q_q;
          neg_q <= job_q.neg_a;
        end else begin
          mag_q <= q_q - p_q;
          neg_q <= job_q.neg_b;
        end
        sh_q <= '0;
        u_q <= '0;
        v_q <= '1;
      end
      S_GCD: begin
        // Binary GCD: u, v are loaded with mag, den on entry to the loop.
        if (u_q == '0 && v_q == '1 && sh_q == '0) begin
          u_q <= mag_q;
          v_q <= (mag_q == '0) ? '0 : den_q;
          sh_q <= '0;
        end else if (u_q[0] == 1'b0 && v_q[0] == 1'b0) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          sh_q <= sh_q + CW'(1);
        end else if (u_q[0] == 1'b0) begin
          u_q <= u_q >> 1;
        end else if (v_q[0] == 1'b0) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= (u_q - v_q) >> 1;
          if (u_q == v_q) begin
            v_q <= '0;
            g_q <= v_q << sh_q;
          end
        end else begin
          v_q <= (v_q - u_q) >> 1;
        end
        cnt_q <= '0;
        pass_q <= 1'b0;
        rem_q <= '0;
        dvd_q <= mag_q;
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle; pass 0 mag, pass 1 den.
        if (cnt_q == CW'(WW - 1)) begin
          rem_q <= '0;
          cnt_q <= '0;
          pass_q <= 1'b1;
          if (!pass_q) begin
            qd_q <= {dvd_q[WW-2:0], ~trial[WW]};
            dvd_q <= den_q;
          end else begin
            rd_q <= {dvd_q[WW-2:0], ~trial[WW]};
          end
        end else begin
          if (trial[WW]) begin
            rem_q <= {rem_q[WW-2:0], dvd_q[WW-1]};
            dvd_q <= {dvd_q[WW-2:0], 1'b0};
          end else begin
            rem_q <= trial[WW-1:0];
            dvd_q <= {dvd_q[WW-2:0], 1'b1};
          end
          cnt_q <= cnt_q + CW'(1);
        end
      end
      S_CHK: begin
        if (mag_q == '0) begin
          ow_q.res_num <= '0;
          ow_q.res_den <= 31'd1;
        end else if (rd_q > LIM || qd_q > LIM + WW'(neg_q)) begin
          ow_q.status <= ST_OVERFLOW;
        end else begin
          ow_q.res_num <= neg_q ? (~qd_q[31:0] + 32'd1) : qd_q[31:0];
          ow_q.res_den <= rd_q[30:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_OUT && !ov_q) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

[verif/rational_add_sub_reduce_unit_tb.sv]
// Testbench for the rational add/subtract/reduce unit: drives operand words,
// predicts each reduced fraction in a scoreboard class and checks every result.
// Depends on rasr_pkg and rational_add_sub_reduce_unit.
`timescale 1ns / 100ps
`default_nettype none
module rational_add_sub_reduce_unit_tb;
  import rasr_pkg::*;

  class fraction_scoreboard;
    out_word_t pending_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function longint unsigned gcd64(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function void note_operands(in_word_t w);
      out_word_t e;
      longint unsigned am, bm, ad, bd, p, q, mag, den, g, lim;
      bit an, bn, pn, qn, neg;
      e.res_num = '0;
      e.res_den = 31'd1;
      e.operands_equal = (w.a_num == w.b_num) && (w.a_den == w.b_den);
      e.status = ST_OK;
      if (w.a_den == 0 || w.b_den == 0) begin
        e.status = ST_ZERO_DEN;
      end else begin
        an = w.a_num[31];
        bn = w.b_num[31];
        am = an ? ((~{32'd0, w.a_num} + 1) & 64'hFFFFFFFF) : {32'd0, w.a_num};
        bm = bn ? ((~{32'd0, w.b_num} + 1) & 64'hFFFFFFFF) : {32'd0, w.b_num};
        ad = 64'(w.a_den);
        bd = 64'(w.b_den);
        p = am * bd;
        q = bm * ad;
        pn = an;
        qn = w.mode ? !bn : bn;
        den = ad * bd;
        if (pn == qn) begin
          mag = p + q;
          neg = pn;
        end else if (p >= q) begin
          mag = p - q;
          neg = pn;
        end else begin
          mag = q - p;
          neg = qn;
        end
        if (mag != 0) begin
          g = gcd64(mag, den);
          mag = mag / g;
          den = den / g;
          lim = (64'd1 << (VALUE_WIDTH - 1)) - 1;
          if (den > lim || mag > lim + (neg ? 1 : 0)) begin
            e.status = ST_OVERFLOW;
          end else begin
            e.res_num = neg ? (~mag[31:0] + 32'd1) : mag[31:0];
            e.res_den = den[30:0];
          end
        end
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", got);
        return;
      end
      e = pending_q.pop_front();
      if (got.res_num !== e.res_num || got.res_den !== e.res_den ||
          got.operands_equal !== e.operands_equal || got.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Mismatch: expected num %0d den %0d eq %0d st %0d, ",
                    "got num %0d den %0d eq %0d st %0d"},
                   $signed(e.res_num), e.res_den, e.operands_equal, e.status,
                   $signed(got.res_num), got.res_den, got.operands_equal, got.status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;

  fraction_scoreboard board = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_off = 0;
  longint unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned zero_den_seen = 0;
  int unsigned overflow_seen = 0;

  always #5 clk_i = ~clk_i;

  rational_add_sub_reduce_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_word_i(in_word_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_word_o(out_word_o)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls plus long hold-offs when requested.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(out_word_o);
      if (out_word_o.status == ST_ZERO_DEN) zero_den_seen++;
      if (out_word_o.status == ST_OVERFLOW) overflow_seen++;
    end
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [31:0] pick_num();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(40) - 20;
      3: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(9))
      0: return 31'h7FFF_FFFF;
      1: return 31'd0;
      2, 3: return 31'($urandom_range(30) + 1);
      4, 5: return 31'($urandom_range(5000) + 1);
      default: return 31'($urandom) | 31'd1;
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_operands(w);
    sent++;
  endtask

  task automatic send_fraction(input logic m, input logic [31:0] an, input logic [30:0] ad,
                               input logic [31:0] bn, input logic [30:0] bd);
    in_word_t w;
    w.mode = m;
    w.a_num = an;
    w.a_den = ad;
    w.b_num = bn;
    w.b_den = bd;
    send_word(w);
  endtask

  task automatic send_random(input int unsigned count);
    in_word_t w;
    repeat (count) begin
      w.mode = 1'($urandom_range(1));
      w.a_num = pick_num();
      w.a_den = pick_den();
      if ($urandom_range(7) == 0) begin
        w.b_num = w.a_num;
        w.b_den = w.a_den;
      end else begin
        w.b_num = pick_num();
        w.b_den = pick_den();
      end
      send_word(w);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_fraction(1'b0, 32'd1, 31'd2, 32'd1, 31'd3);
    send_fraction(1'b1, 32'd1, 31'd2, 32'd1, 31'd2);
    send_fraction(1'b1, 32'd3, 31'd4, 32'd3, 31'd4);
    send_fraction(1'b0, 32'd2, 31'd4, 32'd3, 31'd6);
    send_fraction(1'b0, 32'd0, 31'd1, 32'd0, 31'd7);
    send_fraction(1'b0, 32'd1, 31'd0, 32'd1, 31'd3);
    send_fraction(1'b1, 32'd5, 31'd3, 32'd1, 31'd0);
    send_fraction(1'b0, 32'h7FFF_FFFF, 31'd1, 32'd1, 31'd1);
    send_fraction(1'b1, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
    send_fraction(1'b0, 32'h8000_0000, 31'd1, 32'd0, 31'd1);
    send_fraction(1'b1, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_fraction(1'b0, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
    send_fraction(1'b0, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFE);
    send_fraction(1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_fraction(1'b0, 32'hFFFF_FFFF, 31'd3, 32'd1, 31'd6);
    send_fraction(1'b1, 32'hFFFF_FFFE, 31'd5, 32'h7FFF_FFFF, 31'd3);
    send_fraction(1'b0, 32'd0, 31'd0, 32'd0, 31'd0);
    send_fraction(1'b1, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_fraction(1'b0, 32'hAAAA_AAAA, 31'h5555_5555, 32'h5555_5555, 31'h2AAA_AAAA);
    drain();

    send_idle_pct = 16;
    recv_idle_pct = 62;
    send_random(130);
    hold_off = 400;
    send_random(10);
    drain();

    send_idle_pct = 62;
    recv_idle_pct = 16;
    send_random(130);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(130);
    drain();
    repeat (300) @(posedge clk_i);

    $display("Sent %0d operand words; %0d results checked,", sent, board.checked);
    $display("%0d zero-denominator and %0d overflow results seen.",
             zero_den_seen, overflow_seen);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches, board.pending_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
